// ===== rtl/gbkaf_pkg.sv =====
`default_nettype none
package gbkaf_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd0;
  localparam logic [1:0] REG_ANGLE_NOISE   = 2'd1;
  localparam logic [1:0] REG_BIAS_NOISE    = 2'd2;
  localparam logic [1:0] REG_MEASURE_NOISE = 2'd3;

  // Reset values in Q32.32
  localparam logic [62:0] TS_RST  = 63'd21474836;
  localparam logic [62:0] APN_RST = 63'd4294967;
  localparam logic [62:0] BPN_RST = 63'd4294967;
  localparam logic [62:0] MN_RST  = 63'd429496729600;
  localparam logic signed [63:0] CAA_RST = 64'sd3393024163840000000;
  localparam logic signed [63:0] CAB_RST = -64'sd1357209665536000;
  localparam logic signed [63:0] CBB_RST = 64'sd1073741824000;
  localparam logic signed [63:0] Q_ONE   = 64'sd4294967296;
  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  typedef struct packed {
    logic signed [31:0] measured_angle;
    logic signed [31:0] gyro_rate;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] angle_estimate;
    logic signed [31:0] previous_angle;
    logic signed [31:0] corrected_rate;
    logic signed [31:0] rate_integral;
  } out_word_t;

  // Saturating add
  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [63:0] r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) return a[63] ? S64_MIN : S64_MAX;
    return r;
  endfunction

  // Saturating subtract
  function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [63:0] r;
    r = a - b;
    if (a[63] != b[63] && r[63] != a[63]) return a[63] ? S64_MIN : S64_MAX;
    return r;
  endfunction

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // Signed value from magnitude and sign, saturated
  function automatic logic signed [63:0] from_mag(input logic [63:0] m, input logic neg);
    if (neg) return m[63] ? S64_MIN : -$signed(m);
    return m[63] ? S64_MAX : $signed(m);
  endfunction

  // Q32.32 to Q16.16, floor, saturated
  function automatic logic signed [31:0] narrow(input logic signed [63:0] v);
    if (!v[63] && v[62:47] != 16'h0000) return 32'sh7fffffff;
    if (v[63] && v[62:47] != 16'hffff) return 32'sh80000000;
    return v[47:16];
  endfunction

  // Q16.16 to Q32.32, exact
  function automatic logic signed [63:0] widen(input logic signed [31:0] x);
    return {{16{x[31]}}, x, 16'h0000};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/gyro_bias_kalman_angle_fusion_unit.sv =====
// Two-state Kalman angle/gyro-bias fusion, Q16.16 in and out, Q32.32 inside.
// Input channel: in_valid/in_stall carry one word (measured_angle, gyro_rate).
// Result channel: out_valid/out_stall carry one word per input (new angle,
// previous angle, bias-corrected rate, running integral of Ts * rate).
// Configuration: cfg_wr_en writes cfg_data into register cfg_index
// (0 sample period, 1 angle noise, 2 bias noise, 3 measurement noise).
// One word is worked on at a time; in_stall is high from acceptance until the
// result is loaded into the output register. A single 32x32 multiplier does
// every Q32.32 product (12 products) in four partial products and a finish
// step, and a restoring divider forms both gains at one quotient bit a cycle
// (96 bits). The next word may be accepted in the same cycle that the result
// first sits in the output register.
// A stalled result holds in the output register; a finished step waits for it
// to drain before it loads the next result.
// Reset (synchronous, rst_n low) restores default registers, zero angle and
// bias, and the default covariance; no result is pending after reset.
`default_nettype none
module gyro_bias_kalman_angle_fusion_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire gbkaf_pkg::in_word_t in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output gbkaf_pkg::out_word_t     out_data,
  input  wire logic                cfg_wr_en,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [62:0]         cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;

  // Sequencer steps
  localparam logic [4:0] P_ERR   = 5'd0;
  localparam logic [4:0] P_APRED = 5'd1;
  localparam logic [4:0] P_CSUM  = 5'd2;
  localparam logic [4:0] P_VAA0  = 5'd3;
  localparam logic [4:0] P_TSSQ  = 5'd4;
  localparam logic [4:0] P_VAA1  = 5'd5;
  localparam logic [4:0] P_VAA2  = 5'd6;
  localparam logic [4:0] P_VAB   = 5'd7;
  localparam logic [4:0] P_INNOV = 5'd8;
  localparam logic [4:0] P_GA    = 5'd9;
  localparam logic [4:0] P_GB    = 5'd10;
  localparam logic [4:0] P_ANG   = 5'd11;
  localparam logic [4:0] P_BIAS  = 5'd12;
  localparam logic [4:0] P_CAA   = 5'd13;
  localparam logic [4:0] P_CAB   = 5'd14;
  localparam logic [4:0] P_CBA   = 5'd15;
  localparam logic [4:0] P_CBB   = 5'd16;
  localparam logic [4:0] P_INTEG = 5'd17;
  localparam logic [4:0] P_OUT   = 5'd18;

  logic [1:0] st_r;
  logic [4:0] pc_r;
  logic [62:0] ts_r, apn_r, bpn_r, mn_r;
  logic signed [63:0] ang_r, bias_r, caa_r, cab_r, cba_r, cbb_r, last_r, integ_r;
  logic signed [63:0] meas_r, rate_r, tmp_r, apred_r, vaa_r, vab_r, vbb_r;
  logic signed [63:0] resid_r, innov_r, ga_r, gb_r, oa_r;
  logic signed [63:0] ts_s;
  logic out_valid_r;
  logic out_load;
  gbkaf_pkg::out_word_t out_data_r;

  // Multiplier unit
  logic mbusy_r, mdone_r, mneg_r;
  logic [2:0] mcnt_r;
  logic [63:0] mpa_r, mpb_r;
  logic signed [63:0] mres_r;
  logic [127:0] macc_r;
  logic [31:0] mha, mhb;
  logic [63:0] mpp;
  logic [127:0] mpp_sh;
  logic [63:0] mmag;

  // Divider unit
  logic dbusy_r, ddone_r, dneg_r, dzero_r, dovf_r;
  logic [6:0] dcnt_r;
  logic [95:0] dn_r;
  logic [63:0] dd_r, drem_r, dq_r;
  logic [64:0] dr2;
  logic dbit;
  logic signed [63:0] dres_r;

  logic run, is_mul, is_div, mul_go, mul_take, div_go, div_take;
  logic signed [63:0] op_a, op_b;

  assign ts_s = $signed({1'b0, ts_r});
  assign run  = (st_r == ST_RUN);

  // Load the output register at the end of a step when it is free
  assign out_load = run && (pc_r == P_OUT) && (!out_valid_r || !out_stall);

  // Decode step kind and operands
  always_comb begin
    is_mul = 1'b0;
    is_div = 1'b0;
    op_a   = ts_s;
    op_b   = tmp_r;
    unique case (pc_r)
      P_APRED: begin is_mul = 1'b1; end
      P_VAA0:  begin is_mul = 1'b1; end
      P_TSSQ:  begin is_mul = 1'b1; op_b = ts_s; end
      P_VAA1:  begin is_mul = 1'b1; op_a = tmp_r; op_b = cbb_r; end
      P_VAB:   begin is_mul = 1'b1; op_b = cbb_r; end
      P_GA:    begin is_div = 1'b1; op_a = vaa_r; op_b = innov_r; end
      P_GB:    begin is_div = 1'b1; op_a = vab_r; op_b = innov_r; end
      P_ANG:   begin is_mul = 1'b1; op_a = resid_r; op_b = ga_r; end
      P_BIAS:  begin is_mul = 1'b1; op_a = resid_r; op_b = gb_r; end
      P_CAA:   begin is_mul = 1'b1; op_a = oa_r; op_b = vaa_r; end
      P_CAB:   begin is_mul = 1'b1; op_a = oa_r; op_b = vab_r; end
      P_CBA:   begin is_mul = 1'b1; op_a = gb_r; op_b = vaa_r; end
      P_CBB:   begin is_mul = 1'b1; op_a = gb_r; op_b = vab_r; end
      P_INTEG: begin is_mul = 1'b1; op_b = rate_r; end
      default: begin end
    endcase
    mul_go   = run && is_mul && !mbusy_r && !mdone_r;
    mul_take = run && is_mul && mdone_r;
    div_go   = run && is_div && !dbusy_r && !ddone_r;
    div_take = run && is_div && ddone_r;
  end

  // Partial product of the multiplier
  always_comb begin
    mha  = mcnt_r[0] ? mpa_r[63:32] : mpa_r[31:0];
    mhb  = mcnt_r[1] ? mpb_r[63:32] : mpb_r[31:0];
    mpp  = 64'(mha) * 64'(mhb);
    case (mcnt_r[1:0])
      2'd0:    mpp_sh = {64'd0, mpp};
      2'd3:    mpp_sh = {mpp, 64'd0};
      default: mpp_sh = {32'd0, mpp, 32'd0};
    endcase
    mmag = (macc_r[127:96] != 32'd0) ? {64{1'b1}} : macc_r[95:32];
  end

  // Multiplier sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
      mdone_r <= 1'b0;
      mcnt_r  <= 3'd0;
    end else if (mul_go) begin
      mbusy_r <= 1'b1;
      mcnt_r  <= 3'd0;
      macc_r  <= 128'd0;
      mpa_r   <= gbkaf_pkg::mag(op_a);
      mpb_r   <= gbkaf_pkg::mag(op_b);
      mneg_r  <= op_a[63] ^ op_b[63];
    end else if (mbusy_r) begin
      if (mcnt_r == 3'd4) begin
        mres_r  <= gbkaf_pkg::from_mag(mmag, mneg_r);
        mbusy_r <= 1'b0;
        mdone_r <= 1'b1;
      end else begin
        macc_r <= macc_r + mpp_sh;
        mcnt_r <= mcnt_r + 3'd1;
      end
    end else if (mul_take) begin
      mdone_r <= 1'b0;
    end
  end

  // One quotient bit a cycle
  assign dr2  = {drem_r, dn_r[95]};
  assign dbit = (dr2 >= {1'b0, dd_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
      ddone_r <= 1'b0;
      dcnt_r  <= 7'd0;
    end else if (div_go) begin
      dbusy_r <= 1'b1;
      dcnt_r  <= 7'd0;
      dn_r    <= {gbkaf_pkg::mag(op_a), 32'd0};
      dd_r    <= gbkaf_pkg::mag(op_b);
      drem_r  <= 64'd0;
      dq_r    <= 64'd0;
      dovf_r  <= 1'b0;
      dneg_r  <= op_a[63] ^ op_b[63];
      dzero_r <= (op_b == 64'sd0);
    end else if (dbusy_r) begin
      if (dcnt_r == 7'd96) begin
        dres_r  <= dzero_r ? 64'sd0 :
                   gbkaf_pkg::from_mag(dovf_r ? {64{1'b1}} : dq_r, dneg_r);
        dbusy_r <= 1'b0;
        ddone_r <= 1'b1;
      end else begin
        drem_r <= dbit ? 64'(dr2 - {1'b0, dd_r}) : dr2[63:0];
        dn_r   <= {dn_r[94:0], 1'b0};
        dq_r   <= {dq_r[62:0], dbit};
        if (dcnt_r < 7'd32 && dbit) dovf_r <= 1'b1;
        dcnt_r <= dcnt_r + 7'd1;
      end
    end else if (div_take) begin
      ddone_r <= 1'b0;
    end
  end

  // Configuration, sequencer and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      pc_r        <= P_ERR;
      out_valid_r <= 1'b0;
      ts_r        <= gbkaf_pkg::TS_RST;
      apn_r       <= gbkaf_pkg::APN_RST;
      bpn_r       <= gbkaf_pkg::BPN_RST;
      mn_r        <= gbkaf_pkg::MN_RST;
      ang_r       <= 64'sd0;
      bias_r      <= 64'sd0;
      caa_r       <= gbkaf_pkg::CAA_RST;
      cab_r       <= gbkaf_pkg::CAB_RST;
      cba_r       <= gbkaf_pkg::CAB_RST;
      cbb_r       <= gbkaf_pkg::CBB_RST;
      last_r      <= 64'sd0;
      integ_r     <= 64'sd0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          gbkaf_pkg::REG_SAMPLE_PERIOD: ts_r  <= cfg_data;
          gbkaf_pkg::REG_ANGLE_NOISE:   apn_r <= cfg_data;
          gbkaf_pkg::REG_BIAS_NOISE:    bpn_r <= cfg_data;
          gbkaf_pkg::REG_MEASURE_NOISE: mn_r  <= cfg_data;
          default: begin end
        endcase
      end
      // Load a finished result, else drop a delivered one
      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          if (in_valid) begin
            meas_r <= gbkaf_pkg::widen(in_data.measured_angle);
            rate_r <= gbkaf_pkg::widen(in_data.gyro_rate);
            pc_r   <= P_ERR;
            st_r   <= ST_RUN;
          end
        end
        ST_RUN: begin
          unique case (pc_r)
            P_ERR: begin
              tmp_r <= gbkaf_pkg::ssub(rate_r, bias_r);
              pc_r  <= P_APRED;
            end
            P_APRED: if (mul_take) begin
              apred_r <= gbkaf_pkg::sadd(ang_r, mres_r);
              pc_r    <= P_CSUM;
            end
            P_CSUM: begin
              tmp_r <= gbkaf_pkg::sadd(cab_r, cba_r);
              pc_r  <= P_VAA0;
            end
            P_VAA0: if (mul_take) begin
              vaa_r <= gbkaf_pkg::ssub(caa_r, mres_r);
              pc_r  <= P_TSSQ;
            end
            P_TSSQ: if (mul_take) begin
              tmp_r <= mres_r;
              pc_r  <= P_VAA1;
            end
            P_VAA1: if (mul_take) begin
              vaa_r <= gbkaf_pkg::sadd(vaa_r, mres_r);
              pc_r  <= P_VAA2;
            end
            P_VAA2: begin
              vaa_r   <= gbkaf_pkg::sadd(vaa_r, $signed({1'b0, apn_r}));
              vbb_r   <= gbkaf_pkg::sadd(cbb_r, $signed({1'b0, bpn_r}));
              resid_r <= gbkaf_pkg::ssub(meas_r, apred_r);
              pc_r    <= P_VAB;
            end
            P_VAB: if (mul_take) begin
              vab_r <= gbkaf_pkg::ssub(cab_r, mres_r);
              pc_r  <= P_INNOV;
            end
            P_INNOV: begin
              innov_r <= gbkaf_pkg::sadd(vaa_r, $signed({1'b0, mn_r}));
              pc_r    <= P_GA;
            end
            P_GA: if (div_take) begin
              ga_r <= dres_r;
              oa_r <= gbkaf_pkg::ssub(gbkaf_pkg::Q_ONE, dres_r);
              pc_r <= P_GB;
            end
            P_GB: if (div_take) begin
              gb_r <= dres_r;
              pc_r <= P_ANG;
            end
            P_ANG: if (mul_take) begin
              ang_r <= gbkaf_pkg::sadd(apred_r, mres_r);
              pc_r  <= P_BIAS;
            end
            P_BIAS: if (mul_take) begin
              bias_r <= gbkaf_pkg::sadd(bias_r, mres_r);
              pc_r   <= P_CAA;
            end
            P_CAA: if (mul_take) begin
              caa_r <= mres_r;
              pc_r  <= P_CAB;
            end
            P_CAB: if (mul_take) begin
              cab_r <= mres_r;
              pc_r  <= P_CBA;
            end
            P_CBA: if (mul_take) begin
              cba_r <= gbkaf_pkg::ssub(vab_r, mres_r);
              pc_r  <= P_CBB;
            end
            P_CBB: if (mul_take) begin
              cbb_r <= gbkaf_pkg::ssub(vbb_r, mres_r);
              pc_r  <= P_INTEG;
            end
            P_INTEG: if (mul_take) begin
              integ_r <= gbkaf_pkg::sadd(integ_r, mres_r);
              pc_r    <= P_OUT;
            end
            P_OUT: begin
              // Load the result once the output register is free
              if (out_load) begin
                out_data_r.angle_estimate <= gbkaf_pkg::narrow(ang_r);
                out_data_r.previous_angle <= gbkaf_pkg::narrow(last_r);
                out_data_r.corrected_rate <=
                  gbkaf_pkg::narrow(gbkaf_pkg::ssub(rate_r, bias_r));
                out_data_r.rate_integral  <= gbkaf_pkg::narrow(integ_r);
                last_r      <= ang_r;
                st_r        <= ST_IDLE;
              end
            end
            default: pc_r <= P_ERR;
          endcase
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall  = (st_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // The two arithmetic units never run at once
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mbusy_r && dbusy_r))
    else $error("multiplier and divider busy together");

  // A result only appears at the end of a step
  a_out_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(st_r == ST_RUN && pc_r == P_OUT))
    else $error("result without a finished step");

  // Accepting a word closes the input until the step ends
  a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open right after acceptance");

  // A product result is only held when the sequencer is waiting on it
  a_mdone_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mdone_r |-> (!mbusy_r && run && is_mul))
    else $error("product done outside a multiply step");
`endif

endmodule
`default_nettype wire

// ===== tb/gbkaf_checker.sv =====
`timescale 1ns / 1ps
module gbkaf_checker (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_stall,
  input  wire gbkaf_pkg::in_word_t  in_data,
  input  wire logic                 out_valid,
  input  wire logic                 out_stall,
  input  wire gbkaf_pkg::out_word_t out_data,
  input  wire logic                 cfg_wr_en,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [62:0]          cfg_data,
  output int                        fail_count,
  output int                        pending_count,
  output int                        word_count
);

  typedef logic signed [63:0] q64_t;

  // Filter copy: registers and state
  q64_t ts_q, apn_q, bpn_q, mn_q;
  q64_t ang_q, bias_q, paa_q, pab_q, pba_q, pbb_q, last_q, integ_q;

  gbkaf_pkg::out_word_t fused_q[$];

  localparam q64_t MAXV = 64'sh7fffffffffffffff;
  localparam q64_t MINV = 64'sh8000000000000000;

  function automatic q64_t fx_add(q64_t p, q64_t q);
    logic signed [64:0] r;
    r = 65'(p) + 65'(q);
    if (r > 65'(MAXV)) return MAXV;
    if (r < 65'(MINV)) return MINV;
    return r[63:0];
  endfunction

  function automatic q64_t fx_sub(q64_t p, q64_t q);
    logic signed [64:0] r;
    r = 65'(p) - 65'(q);
    if (r > 65'(MAXV)) return MAXV;
    if (r < 65'(MINV)) return MINV;
    return r[63:0];
  endfunction

  function automatic q64_t fx_sign(logic [127:0] m, logic neg);
    if (neg) return (m >= 128'h8000000000000000) ? MINV : -$signed(m[63:0]);
    return (m > 128'h7fffffffffffffff) ? MAXV : $signed(m[63:0]);
  endfunction

  function automatic logic [63:0] fx_mag(q64_t v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // Truncating Q32.32 product
  function automatic q64_t fx_mul(q64_t p, q64_t q);
    logic [127:0] m;
    m = ({64'd0, fx_mag(p)} * {64'd0, fx_mag(q)}) >> 32;
    return fx_sign(m, p[63] != q[63]);
  endfunction

  // Truncating Q32.32 quotient; zero divisor gives zero
  function automatic q64_t fx_div(q64_t n, q64_t d);
    logic [127:0] m;
    if (d == 0) return 0;
    m = ({64'd0, fx_mag(n)} << 32) / {64'd0, fx_mag(d)};
    return fx_sign(m, n[63] != d[63]);
  endfunction

  function automatic q64_t fx_widen(logic signed [31:0] x);
    return 64'(x) * 64'sd65536;
  endfunction

  function automatic logic signed [31:0] fx_narrow(q64_t v);
    q64_t s;
    s = v >>> 16;
    if (s > 64'sd2147483647) return 32'sh7fffffff;
    if (s < -64'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  // Advance the filter by one word and queue its result
  task automatic fuse_step(gbkaf_pkg::in_word_t w);
    q64_t meas, rate, apred, vaa, vab, vbb, resid, innov, ka, kb;
    gbkaf_pkg::out_word_t o;
    meas = fx_widen(w.measured_angle);
    rate = fx_widen(w.gyro_rate);
    apred = fx_add(ang_q, fx_mul(ts_q, fx_sub(rate, bias_q)));
    vaa = fx_sub(paa_q, fx_mul(ts_q, fx_add(pab_q, pba_q)));
    vaa = fx_add(vaa, fx_mul(fx_mul(ts_q, ts_q), pbb_q));
    vaa = fx_add(vaa, apn_q);
    vab = fx_sub(pab_q, fx_mul(ts_q, pbb_q));
    vbb = fx_add(pbb_q, bpn_q);
    resid = fx_sub(meas, apred);
    innov = fx_add(vaa, mn_q);
    ka = fx_div(vaa, innov);
    kb = fx_div(vab, innov);
    ang_q = fx_add(apred, fx_mul(resid, ka));
    bias_q = fx_add(bias_q, fx_mul(resid, kb));
    paa_q = fx_mul(fx_sub(gbkaf_pkg::Q_ONE, ka), vaa);
    pab_q = fx_mul(fx_sub(gbkaf_pkg::Q_ONE, ka), vab);
    pba_q = fx_sub(vab, fx_mul(kb, vaa));
    pbb_q = fx_sub(vbb, fx_mul(kb, vab));
    integ_q = fx_add(integ_q, fx_mul(ts_q, rate));
    o.angle_estimate = fx_narrow(ang_q);
    o.previous_angle = fx_narrow(last_q);
    o.corrected_rate = fx_narrow(fx_sub(rate, bias_q));
    o.rate_integral = fx_narrow(integ_q);
    last_q = ang_q;
    fused_q.push_back(o);
  endtask

  task automatic check_field(string name, logic signed [31:0] exp_v, logic signed [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    gbkaf_pkg::out_word_t e;
    if (!rst_n) begin
      ts_q = 64'(gbkaf_pkg::TS_RST);
      apn_q = 64'(gbkaf_pkg::APN_RST);
      bpn_q = 64'(gbkaf_pkg::BPN_RST);
      mn_q = 64'(gbkaf_pkg::MN_RST);
      ang_q = 0; bias_q = 0; last_q = 0; integ_q = 0;
      paa_q = gbkaf_pkg::CAA_RST; pab_q = gbkaf_pkg::CAB_RST;
      pba_q = gbkaf_pkg::CAB_RST; pbb_q = gbkaf_pkg::CBB_RST;
      fused_q.delete();
      fail_count = 0;
      word_count = 0;
    end else begin
      // Compare the outgoing word with the oldest prediction
      if (out_valid && !out_stall) begin
        word_count++;
        if (fused_q.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          e = fused_q.pop_front();
          check_field("angle_estimate", e.angle_estimate, out_data.angle_estimate);
          check_field("previous_angle", e.previous_angle, out_data.previous_angle);
          check_field("corrected_rate", e.corrected_rate, out_data.corrected_rate);
          check_field("rate_integral", e.rate_integral, out_data.rate_integral);
        end
      end
      // Track register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          gbkaf_pkg::REG_SAMPLE_PERIOD: ts_q = {1'b0, cfg_data};
          gbkaf_pkg::REG_ANGLE_NOISE:   apn_q = {1'b0, cfg_data};
          gbkaf_pkg::REG_BIAS_NOISE:    bpn_q = {1'b0, cfg_data};
          gbkaf_pkg::REG_MEASURE_NOISE: mn_q = {1'b0, cfg_data};
          default: ;
        endcase
      end
      if (in_valid && !in_stall) fuse_step(in_data);
    end
    pending_count = fused_q.size();
  end
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_wr_en;
  gbkaf_pkg::in_word_t in_data;
  gbkaf_pkg::out_word_t out_data;
  logic [1:0] cfg_index;
  logic [62:0] cfg_data;
  int fail_count, pending_count, word_count;
  int cycle_count;
  int hold_cycles;
  bit hold_on;
  int sent_count;

  localparam int CycleLimit = 5000000;

  gyro_bias_kalman_angle_fusion_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  gbkaf_checker u_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count), .word_count(word_count)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Stop a hung run
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 400) : $urandom_range(0, 3);
  endfunction

  // Receiver: random stalls, none while sent_count is 201 to 259, plus one long hold-off on request
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_on) begin
        out_stall <= 1'b1;
        for (n = 0; n < hold_cycles; n++) @(posedge clk);
        hold_on = 0;
        out_stall <= 1'b0;
      end else if (sent_count > 200 && sent_count < 260) begin
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat (gap_len() + 1) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Write all four registers on consecutive edges
  task automatic write_all(logic [62:0] ts, logic [62:0] apn, logic [62:0] bpn,
                           logic [62:0] mn);
    cfg_wr_en <= 1'b1;
    cfg_index <= gbkaf_pkg::REG_SAMPLE_PERIOD;
    cfg_data <= ts;
    @(posedge clk);
    cfg_index <= gbkaf_pkg::REG_ANGLE_NOISE;
    cfg_data <= apn;
    @(posedge clk);
    cfg_index <= gbkaf_pkg::REG_BIAS_NOISE;
    cfg_data <= bpn;
    @(posedge clk);
    cfg_index <= gbkaf_pkg::REG_MEASURE_NOISE;
    cfg_data <= mn;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Offer one word and wait for its acceptance
  task automatic send_word(logic signed [31:0] ang, logic signed [31:0] rate, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.measured_angle <= ang;
    in_data.gyro_rate <= rate;
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  // Stop offering and wait until every result has come
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_q16();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 65535)) - 32'sd32768;
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic logic [62:0] rand_cfg();
    case ($urandom_range(0, 4))
      0: return 63'd0;
      1: return {63{1'b1}};
      2: return 63'($urandom_range(1, 1 << 24));
      default: return 63'({$urandom(), $urandom()});
    endcase
  endfunction

  initial begin
    int i, ph;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_index = gbkaf_pkg::REG_SAMPLE_PERIOD;
    cfg_data = '0;
    hold_on = 0;
    hold_cycles = 0;
    sent_count = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: default registers, field extremes, then all-ones and all-zero registers
    send_word(32'sh7fffffff, 32'sh7fffffff, 0);
    send_word(32'sh80000000, 32'sh80000000, 0);
    send_word(32'sh7fffffff, 32'sh80000000, 0);
    send_word(32'sh80000000, 32'sh7fffffff, 0);
    send_word(0, 0, 0);
    send_word(32'sh00010000, 32'shffff0000, 1);
    send_word(32'shffffffff, 32'sh00000001, 1);
    send_word(32'sh55555555, 32'shaaaaaaaa, 1);
    drain();
    write_all({63{1'b1}}, {63{1'b1}}, {63{1'b1}}, {63{1'b1}});
    for (i = 0; i < 5; i++) send_word(rand_q16(), rand_q16(), 1);
    drain();
    write_all(63'd0, 63'd0, 63'd0, 63'd0);
    for (i = 0; i < 6; i++) send_word(rand_q16(), rand_q16(), 0);
    drain();

    // Random phases with new settings between them
    for (ph = 0; ph < 8; ph++) begin
      if (ph == 0) begin
        write_all(63'd21474836, 63'd4294967, 63'd4294967, 63'd429496729600);
      end else begin
        write_all(rand_cfg(), rand_cfg(), rand_cfg(), rand_cfg());
      end
      for (i = 0; i < 80; i++) begin
        if (ph == 2 && i == 10) begin
          hold_cycles = 3000;
          hold_on = 1;
        end
        if (ph == 3 && i == 40) drain();
        send_word(rand_q16(), rand_q16(), $urandom_range(0, 3) != 0);
      end
      drain();
    end

    drain();
    repeat (400) @(posedge clk);
    $display("Sent %0d words over 8 register settings plus extremes; %0d results checked.",
             sent_count, word_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/gbkaf_pkg.sv
rtl/gyro_bias_kalman_angle_fusion_unit.sv
tb/gbkaf_checker.sv
tb/testbench.sv
